[rtl/sblru_pkg.sv]
// Shared types and constants for the size-budget LRU cache directory.
// No dependencies.
package sblru_pkg;
  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int SIZE_W    = 31;
  localparam int CAP_W     = 27;
  localparam int STAMP_W   = 32;
  localparam int EVICT_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 27'd2000;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_INSERTED = 2'd1,
    OUT_TOO_BIG  = 2'd2,
    OUT_NOT_FND  = 2'd3
  } outcome_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request, bump counter
    logic scan_clr;   // restart a slot walk
    logic scan_step;  // examine one slot
    logic do_hit;     // refresh stamp of found slot
    logic do_evict;   // evict best slot
    logic do_insert;  // write new entry into free slot
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // walk just examined the last slot
    logic hit;        // key match found
    logic any_valid;
    logic any_free;
    logic exists;
    logic too_big;
    logic over;       // total + size > capacity
  } dp_sts_t;
endpackage

[rtl/size_budget_lru_cache_directory.sv]
// Size-budget LRU cache directory, top level.
// A request is answered after one table walk; an insertion may evict entries first,
// with one further table walk after each eviction.
// Throughput: one request at a time; a new one is taken after the result transfers.
// Reset (rst_n, synchronous): table empty, request counter and byte total zero, budget 2000 bytes.
module size_budget_lru_cache_directory import sblru_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KEY_W-1:0]   in_object_key,
  input  logic [SIZE_W-1:0]  in_object_size,
  input  logic               in_object_exists,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_outcome,
  output logic [EVICT_W-1:0] out_evicted_count,
  output logic [CAP_W-1:0]   out_bytes_used,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   cfg_capacity_bytes
);
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  outcome_t         oc;
  logic [CAP_W-1:0] cap_r;

  assign cfg_ready   = 1'b1;
  assign out_outcome = oc;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_RESET;
    else if (cfg_valid) cap_r <= cfg_capacity_bytes;
  end

  sblru_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .res_outcome(oc), .cmd, .sts
  );

  sblru_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_key(in_object_key), .in_size(in_object_size),
    .in_exists(in_object_exists), .capacity(cap_r),
    .evicted(out_evicted_count), .total(out_bytes_used)
  );

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_evicted_count <= EVICT_W'(ENTRIES)) else $error("evict count");
  a_evict_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome != 2'(OUT_INSERTED)) |-> out_evicted_count == '0)
    else $error("eviction without insertion");
`endif
endmodule

[rtl/sblru_datapath.sv]
// Datapath: entry table, counters, serial key/LRU/free-slot walk.
// Depends on sblru_pkg.
module sblru_datapath import sblru_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [SIZE_W-1:0]   in_size,
  input  logic                in_exists,
  input  logic [CAP_W-1:0]    capacity,
  output logic [EVICT_W-1:0]  evicted,
  output logic [CAP_W-1:0]    total
);
  logic [ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [CAP_W-1:0]   bytes_mem [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  logic [KEY_W-1:0]   key_r;
  logic [SIZE_W-1:0]  size_r;
  logic               exists_r;
  logic [STAMP_W-1:0] now_r, cnt_r;
  logic [CAP_W-1:0]   total_r;
  logic [EVICT_W-1:0] evict_r;

  logic [IDX_W:0]     idx_r;
  logic               hit_r, best_ok_r, free_ok_r;
  logic [IDX_W-1:0]   hit_idx_r, best_idx_r, free_idx_r;
  logic [STAMP_W-1:0] best_age_r;

  logic [IDX_W-1:0]   i;
  logic [STAMP_W-1:0] age;
  logic [SIZE_W:0]    need;

  assign i    = idx_r[IDX_W-1:0];
  // age is taken against the already bumped counter
  assign age  = cnt_r - stamp_mem[i];
  assign need = {{(SIZE_W+1-CAP_W){1'b0}}, total_r} + {1'b0, size_r};

  assign sts.scan_done = (idx_r == (IDX_W+1)'(ENTRIES - 1)) && cmd.scan_step;
  assign sts.hit       = hit_r;
  assign sts.any_valid = best_ok_r;
  assign sts.any_free  = free_ok_r;
  assign sts.exists    = exists_r;
  assign sts.too_big   = {1'b0, size_r} > {5'd0, capacity};
  assign sts.over      = need > {5'd0, capacity};
  assign evicted = evict_r;
  assign total   = total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      if (cmd.load) cnt_r <= cnt_r + 1'b1;
      if (cmd.do_evict) begin
        valid_r[best_idx_r] <= 1'b0;
        total_r <= total_r - bytes_mem[best_idx_r];
      end
      if (cmd.do_insert) begin
        valid_r[free_idx_r] <= 1'b1;
        total_r <= total_r + size_r[CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_key;
      size_r   <= in_size;
      exists_r <= in_exists;
      now_r    <= cnt_r;
      evict_r  <= '0;
    end
    if (cmd.do_evict) evict_r <= evict_r + 1'b1;
    if (cmd.do_hit) stamp_mem[hit_idx_r] <= now_r;
    if (cmd.do_insert) begin
      key_mem[free_idx_r]   <= key_r;
      bytes_mem[free_idx_r] <= size_r[CAP_W-1:0];
      stamp_mem[free_idx_r] <= now_r;
    end
    if (cmd.load || cmd.scan_clr) begin
      idx_r     <= '0;
      hit_r     <= 1'b0;
      best_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (valid_r[i]) begin
        if (!hit_r && key_mem[i] == key_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= i;
        end
        // strict compare keeps the lowest slot on equal age
        if (!best_ok_r || age > best_age_r) begin
          best_ok_r  <= 1'b1;
          best_idx_r <= i;
          best_age_r <= age;
        end
      end else if (!free_ok_r) begin
        free_ok_r  <= 1'b1;
        free_idx_r <= i;
      end
    end
  end
endmodule

[rtl/sblru_ctrl.sv]
// Controller FSM: sequences search, evictions and insertion per request.
// Depends on sblru_pkg.
module sblru_ctrl import sblru_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output outcome_t res_outcome,
  output dp_cmd_t  cmd,
  input  dp_sts_t  sts
);
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_RESCAN = 6'b001000,
    S_FIT    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t   state_r, state_nxt;
  outcome_t oc_r, oc_nxt;

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign res_outcome = oc_r;

  always_comb begin
    state_nxt = state_r;
    oc_nxt    = oc_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.hit) begin
          cmd.do_hit = 1'b1; oc_nxt = OUT_HIT; state_nxt = S_OUT;
        end else if (!sts.exists) begin
          oc_nxt = OUT_NOT_FND; state_nxt = S_OUT;
        end else if (sts.too_big) begin
          oc_nxt = OUT_TOO_BIG; state_nxt = S_OUT;
        end else begin
          oc_nxt = OUT_INSERTED; state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        // one eviction per pass while over budget, then one more if full
        if ((sts.over || !sts.any_free) && sts.any_valid) begin
          cmd.do_evict = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_RESCAN;
        end else begin
          cmd.do_insert = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_RESCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_FIT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oc_r    <= OUT_HIT;
    end else begin
      state_r <= state_nxt;
      oc_r    <= oc_nxt;
    end
  end
endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for the size-budget LRU cache directory.
// Needs sblru_pkg and size_budget_lru_cache_directory; random driver and monitor
// with idle gaps, predicted results queued and compared field by field.
module testbench;
  import sblru_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic              exists;
  } request_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [EVICT_W-1:0] evicted;
    logic [CAP_W-1:0]   used;
  } verdict_t;

  // an entry in the pending queue is a request, a budget change or a drain marker
  typedef struct packed {
    logic              is_cap;
    logic [CAP_W-1:0]  cap;
    logic              drain;
    request_t          req;
  } job_t;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KEY_W-1:0] in_object_key = '0;
  logic [SIZE_W-1:0] in_object_size = '0;
  logic in_object_exists = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_outcome;
  logic [EVICT_W-1:0] out_evicted_count;
  logic [CAP_W-1:0] out_bytes_used;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_capacity_bytes = '0;

  size_budget_lru_cache_directory dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic               slot_valid [ENTRIES];
  logic [KEY_W-1:0]   slot_key   [ENTRIES];
  logic [CAP_W-1:0]   slot_bytes [ENTRIES];
  logic [STAMP_W-1:0] slot_stamp [ENTRIES];
  logic [STAMP_W-1:0] req_clock;
  logic [CAP_W-1:0]   held_bytes;
  logic [CAP_W-1:0]   budget;

  verdict_t expected_q[$];
  job_t     jobs[$];
  int       errors = 0;
  int       idle_cycles = 0;
  logic     stim_done = 1'b0;

  function automatic int oldest_slot();
    int best;
    logic [STAMP_W-1:0] age, best_age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i]) begin
        age = req_clock - slot_stamp[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic verdict_t serve_request(request_t r);
    verdict_t v;
    logic [STAMP_W-1:0] now;
    int hit, s;
    now = req_clock;
    req_clock = req_clock + 1'b1;
    hit = -1;
    v.evicted = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && slot_valid[i] && slot_key[i] == r.key) hit = i;
    if (hit >= 0) begin
      slot_stamp[hit] = now;
      v.outcome = OUT_HIT;
    end else if (!r.exists) begin
      v.outcome = OUT_NOT_FND;
    end else if (r.size > budget) begin
      v.outcome = OUT_TOO_BIG;
    end else begin
      while (64'(held_bytes) + 64'(r.size) > 64'(budget)) begin
        s = oldest_slot();
        if (s < 0) break;
        held_bytes = held_bytes - slot_bytes[s];
        slot_valid[s] = 1'b0;
        v.evicted++;
      end
      s = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (!slot_valid[i]) s = i;
      if (s < 0) begin
        s = oldest_slot();
        held_bytes = held_bytes - slot_bytes[s];
        v.evicted++;
      end
      slot_valid[s] = 1'b1;
      slot_key[s] = r.key;
      slot_bytes[s] = CAP_W'(r.size);
      slot_stamp[s] = now;
      held_bytes = held_bytes + CAP_W'(r.size);
      v.outcome = OUT_INSERTED;
    end
    v.used = held_bytes;
    return v;
  endfunction

  function automatic void push_req(logic [KEY_W-1:0] k, logic [SIZE_W-1:0] sz, logic ex);
    job_t j;
    j = '0;
    j.req.key = k;
    j.req.size = sz;
    j.req.exists = ex;
    jobs.insert(jobs.size(), j);
  endfunction

  function automatic void push_cap(logic [CAP_W-1:0] c);
    job_t j;
    j = '0;
    j.is_cap = 1'b1;
    j.cap = c;
    jobs.insert(jobs.size(), j);
  endfunction

  function automatic void push_drain();
    job_t j;
    j = '0;
    j.drain = 1'b1;
    jobs.insert(jobs.size(), j);
  endfunction

  // small key pool so that hits and evictions are common
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return KEY_W'($urandom_range(0, 40)) ^ 32'hA5A5_0000;
    return $urandom;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(logic [CAP_W-1:0] c);
    case ($urandom_range(0, 9))
      0: return SIZE_W'($urandom);
      1: return '0;
      2: return SIZE_W'(c) + SIZE_W'($urandom_range(0, 2));
      default: return SIZE_W'($urandom_range(0, 32'(c) / 4 + 1));
    endcase
  endfunction

  initial begin
    logic [CAP_W-1:0] caps [5];
    for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
    req_clock = '0;
    held_bytes = '0;
    budget = CAP_RESET;

    // directed: hit/miss basics, size extremes, absent objects, table full
    push_req(32'h0, 31'd0, 1'b1);
    push_req(32'hFFFF_FFFF, 31'd2000, 1'b1);
    push_req(32'h0, 31'h7FFF_FFFF, 1'b0);
    push_req(32'h1234, 31'd2001, 1'b1);
    push_req(32'h1235, 31'h7FFF_FFFF, 1'b1);
    push_req(32'h1236, 31'd5, 1'b0);
    push_req(32'h1237, 31'd700, 1'b1);
    push_req(32'h1238, 31'd700, 1'b1);
    push_req(32'h0, 31'd1, 1'b1);
    for (int i = 0; i < 17; i++) push_req(32'h100 + i, 31'd0, 1'b1);
    push_drain();
    push_cap(27'd1);
    push_req(32'h5555_AAAA, 31'd1, 1'b1);
    push_drain();
    push_cap(27'd0);
    push_req(32'h7, 31'd0, 1'b1);
    push_req(32'h8, 31'd1, 1'b1);
    push_drain();
    push_cap(27'h7FF_FFFF);
    push_req(32'h9, 31'h07FF_FFFF, 1'b1);
    push_req(32'hA, 31'h0800_0000, 1'b1);

    caps[0] = 27'd2000;
    caps[1] = 27'd0;
    caps[2] = 27'h7FF_FFFF;
    caps[3] = 27'd300;
    caps[4] = 27'd64;
    for (int phase = 0; phase < 9; phase++) begin
      logic [CAP_W-1:0] c;
      c = (phase < 5) ? caps[phase] : CAP_W'($urandom_range(1, 5000));
      push_drain();
      push_cap(c);
      for (int n = 0; n < 100; n++) push_req(pick_key(), pick_size(c), $urandom_range(0, 7) != 0);
    end
  end

  // driver
  int   send_gap = 0;
  logic holding = 1'b0;
  logic settling = 1'b0;
  int   settle = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        budget = cfg_capacity_bytes;
        cfg_valid <= 1'b0;
      end else if (in_valid && !in_stall) begin
        expected_q.insert(expected_q.size(),
                          serve_request('{in_object_key, in_object_size, in_object_exists}));
        in_valid <= 1'b0;
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      end else if (!in_valid && !cfg_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (jobs.size() == 0) begin
          stim_done <= 1'b1;
        end else if (jobs[0].drain || jobs[0].is_cap) begin
          // budget writes only once the block is idle, plus a settling margin
          if (expected_q.size() != 0) begin
            settling = 1'b0;
          end else if (!settling) begin
            settling = 1'b1;
            settle = 4 * ENTRIES * 17;
          end else if (settle > 0) begin
            settle--;
          end else begin
            settling = 1'b0;
            if (jobs[0].is_cap) begin
              cfg_capacity_bytes <= jobs[0].cap;
              cfg_valid <= 1'b1;
            end
            void'(jobs.pop_front());
          end
        end else begin
          in_object_key <= jobs[0].req.key;
          in_object_size <= jobs[0].req.size;
          in_object_exists <= jobs[0].req.exists;
          in_valid <= 1'b1;
          void'(jobs.pop_front());
        end
      end
    end
  end

  // monitor with random back-pressure
  int stall_left = 0;
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer outcome=%0d", out_outcome);
        end else begin
          e = expected_q.pop_front();
          if (out_outcome !== e.outcome || out_evicted_count !== e.evicted
              || out_bytes_used !== e.used) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                       e.outcome, e.evicted, e.used,
                       out_outcome, out_evicted_count, out_bytes_used);
          end
        end
        stall_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || (jobs.size() != 0 && (jobs[0].drain || jobs[0].is_cap) && expected_q.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_q.size() == 0);
    repeat (4 * ENTRIES * 17) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
